[src/mscd_pkg.sv]
// Shared types and constants for the microcoded stack CPU datapath.
`timescale 1ns / 1ps
`default_nettype none

package mscd_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_EXEC,
      ST_MEM,
      ST_DONE
   } state_type;

   // Microword, MSB first.
   typedef struct packed {
      logic [8:0] seq_addr;
      logic [2:0] jam;       // bit0 JAMZ, bit1 JAMN, bit2 JMPC
      logic [7:0] alu_code;
      logic [8:0] c_mask;    // bit0 MAR .. bit8 H
      logic [2:0] mem_op;    // bit0 fetch, bit1 read, bit2 write
      logic [3:0] b_sel;
   } uword_type;

   localparam logic [1:0] FUNC_STEP     = 2'd0;
   localparam logic [1:0] FUNC_CS_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_MEM_LOAD = 2'd2;

   localparam logic [7:0] ALU_A       = 8'h18;
   localparam logic [7:0] ALU_B       = 8'h14;
   localparam logic [7:0] ALU_SLL8    = 8'h54;
   localparam logic [7:0] ALU_SRL8    = 8'h94;
   localparam logic [7:0] ALU_SLL7SR1 = 8'hD4;
   localparam logic [7:0] ALU_NOT_A   = 8'h1A;
   localparam logic [7:0] ALU_NOT_B   = 8'h2C;
   localparam logic [7:0] ALU_ADD     = 8'h3C;
   localparam logic [7:0] ALU_ADD_INC = 8'h3D;
   localparam logic [7:0] ALU_INC_A   = 8'h39;
   localparam logic [7:0] ALU_INC_B   = 8'h35;
   localparam logic [7:0] ALU_SUB     = 8'h3F;
   localparam logic [7:0] ALU_DEC_B   = 8'h36;
   localparam logic [7:0] ALU_NEG_A   = 8'h3B;
   localparam logic [7:0] ALU_AND     = 8'h0C;
   localparam logic [7:0] ALU_OR      = 8'h1C;
   localparam logic [7:0] ALU_ZERO    = 8'h10;
   localparam logic [7:0] ALU_ONE     = 8'h31;
   localparam logic [7:0] ALU_ONES    = 8'h32;

   localparam logic [3:0] BSEL_MDR  = 4'd0;
   localparam logic [3:0] BSEL_PC   = 4'd1;
   localparam logic [3:0] BSEL_MBRU = 4'd2;
   localparam logic [3:0] BSEL_MBRS = 4'd3;
   localparam logic [3:0] BSEL_SP   = 4'd4;
   localparam logic [3:0] BSEL_LV   = 4'd5;
   localparam logic [3:0] BSEL_CPP  = 4'd6;
   localparam logic [3:0] BSEL_TOS  = 4'd7;
   localparam logic [3:0] BSEL_OPC  = 4'd8;

endpackage

`default_nettype wire

[src/mscd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mscd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/mscd_alu.sv]
// 32-bit ALU of the datapath; unknown codes pass the previous result.
`timescale 1ns / 1ps
`default_nettype none

module mscd_alu
   import mscd_pkg::*;
(
   input  wire logic [7:0]  code,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   input  wire logic [31:0] prev,
   output logic      [31:0] result
);

   always_comb begin
      unique case (code)
         ALU_A:       result = a;
         ALU_B:       result = b;
         ALU_SLL8:    result = {b[23:0], 8'h00};
         ALU_SRL8:    result = {8'h00, b[31:8]};
         ALU_SLL7SR1: result = {1'b0, b[24:0], 6'b000000};
         ALU_NOT_A:   result = ~a;
         ALU_NOT_B:   result = ~b;
         ALU_ADD:     result = a + b;
         ALU_ADD_INC: result = a + b + 32'd1;
         ALU_INC_A:   result = a + 32'd1;
         ALU_INC_B:   result = b + 32'd1;
         ALU_SUB:     result = b - a;
         ALU_DEC_B:   result = b - 32'd1;
         ALU_NEG_A:   result = 32'd0 - a;
         ALU_AND:     result = a & b;
         ALU_OR:      result = a | b;
         ALU_ZERO:    result = 32'd0;
         ALU_ONE:     result = 32'd1;
         ALU_ONES:    result = 32'hFFFF_FFFF;
         default:     result = prev;
      endcase
   end

endmodule

`default_nettype wire

[src/microcoded_stack_cpu_datapath_core.sv]
// Top level: microprogrammed stack-machine datapath with control store and main memory.
//
// Usage: one word in on req_* (valid/ready), one result word out on rsp_* per input word.
// req_func = step runs one microcycle; the control store load and memory byte load
// fill the 512-entry control store and main memory. Each result word carries the
// micro PC, all registers and the N/Z flags as they stand after that input word.
// A step passes the execute and memory states before its result is registered, a load
// only the load state. Back-to-back steps are paced by the loop through the registered
// control store and main memory reads; the next micro PC is forwarded to the control
// store in the memory cycle, where the next step may already be accepted. Loads go one
// per cycle while the output register is free. Control store words are written at the
// accepting edge, so a step right behind a load sees the new word.
// Main memory is four byte lanes, duplicated so fetch and word read use their own port.
// MEMORY_BYTES must be a power of two.
// Reset: the state and datapath registers clear, then a pass over the MEMORY_BYTES/4
// rows zeroes main memory; req_ready is low during it. The control store is not cleared.
// Stall: one output register parts the sides; while rsp_ready is low a finished result
// waits and the next word is held off until the output register frees, except when idle.
`timescale 1ns / 1ps
`default_nettype none

module microcoded_stack_cpu_datapath_core
   import mscd_pkg::*;
#(
   parameter int MEMORY_BYTES = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [12:0] req_addr,
   input  wire logic [35:0] req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [8:0]  rsp_mpc,
   output logic      [31:0] rsp_pc,
   output logic      [7:0]  rsp_mbr,
   output logic      [31:0] rsp_mar,
   output logic      [31:0] rsp_mdr,
   output logic      [31:0] rsp_sp,
   output logic      [31:0] rsp_lv,
   output logic      [31:0] rsp_cpp,
   output logic      [31:0] rsp_tos,
   output logic      [31:0] rsp_opc,
   output logic      [31:0] rsp_hold,
   output logic      [1:0]  rsp_flags
);

   localparam int MEM_AW = $clog2(MEMORY_BYTES);
   localparam int ROW_W  = MEM_AW - 2;
   localparam int ROWS   = MEMORY_BYTES / 4;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   state_type state_ff, state_in;

   // architectural state
   logic [8:0]  mpc_ff, mpc_in;
   logic [31:0] pc_ff, pc_in, mar_ff, mar_in, mdr_ff, mdr_in;
   logic [7:0]  mbr_ff, mbr_in;
   logic [31:0] sp_ff, sp_in, lv_ff, lv_in, cpp_ff, cpp_in;
   logic [31:0] tos_ff, tos_in, opc_ff, opc_in, h_ff, h_in;
   logic [31:0] blatch_ff, blatch_in, alu_ff, alu_in;
   logic        n_ff, n_in, z_ff, z_in;

   logic [ROW_W-1:0] clr_row_ff, clr_row_in;

   // latched load word
   logic [1:0]  ld_func_ff;
   logic [12:0] ld_addr_ff;
   logic [7:0]  ld_data_ff;

   logic        rsp_valid_ff, rsp_valid_in;

   // control
   logic accept, slot_free, emit;
   logic do_clear, do_load, do_exec, do_mem;

   // control store
   logic [35:0] cs_rd_data;
   uword_type   mir;
   logic        cs_wr_en;

   // main memory lanes
   logic [7:0]       word_rd  [4];
   logic [7:0]       fetch_rd [4];
   logic [31:0]      rd_word;
   logic [31:0]      ld_addr_ext;
   logic [31:0]      alu_res;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign mir       = uword_type'(cs_rd_data);
   assign rd_word   = {word_rd[3], word_rd[2], word_rd[1], word_rd[0]};
   assign ld_addr_ext = {19'd0, ld_addr_ff};

   // ---------------- sequencer ----------------
   always_comb begin
      req_ready = 1'b0;
      emit      = 1'b0;
      do_clear  = 1'b0;
      do_load   = 1'b0;
      do_exec   = 1'b0;
      do_mem    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: do_clear = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_LOAD: begin
            do_load = 1'b1;   // idempotent write, repeats harmlessly while stalled
            if (slot_free) begin
               emit      = 1'b1;
               req_ready = 1'b1;
            end
         end
         ST_EXEC:  do_exec = 1'b1;
         ST_MEM: begin
            do_mem = 1'b1;
            if (slot_free) begin
               emit      = 1'b1;
               req_ready = 1'b1;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               emit      = 1'b1;
               req_ready = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXEC: state_in = ST_MEM;
         default: begin
            priority if (accept) begin
               state_in = (req_func == FUNC_STEP) ? ST_EXEC : ST_LOAD;
            end else if (emit) begin
               state_in = ST_IDLE;
            end else if (state_ff == ST_MEM) begin
               state_in = ST_DONE;
            end
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   mscd_alu u_alu (
      .code   (mir.alu_code),
      .a      (h_ff),
      .b      (blatch_in),
      .prev   (alu_ff),
      .result (alu_res)
   );

   always_comb begin
      mpc_in    = mpc_ff;
      pc_in     = pc_ff;
      mar_in    = mar_ff;
      mdr_in    = mdr_ff;
      mbr_in    = mbr_ff;
      sp_in     = sp_ff;
      lv_in     = lv_ff;
      cpp_in    = cpp_ff;
      tos_in    = tos_ff;
      opc_in    = opc_ff;
      h_in      = h_ff;
      blatch_in = blatch_ff;
      alu_in    = alu_ff;
      n_in      = n_ff;
      z_in      = z_ff;

      if (do_exec) begin
         unique case (mir.b_sel)
            BSEL_MDR:  blatch_in = mdr_ff;
            BSEL_PC:   blatch_in = pc_ff;
            BSEL_MBRU: blatch_in = {24'd0, mbr_ff};
            BSEL_MBRS: blatch_in = {{24{mbr_ff[7]}}, mbr_ff};
            BSEL_SP:   blatch_in = sp_ff;
            BSEL_LV:   blatch_in = lv_ff;
            BSEL_CPP:  blatch_in = cpp_ff;
            BSEL_TOS:  blatch_in = tos_ff;
            BSEL_OPC:  blatch_in = opc_ff;
            default:   blatch_in = blatch_ff;
         endcase
         alu_in = alu_res;
         n_in   = alu_res[31];
         z_in   = (alu_res == 32'd0);
         if (mir.c_mask[0]) mar_in = alu_res;
         if (mir.c_mask[1]) mdr_in = alu_res;
         if (mir.c_mask[2]) pc_in  = alu_res;
         if (mir.c_mask[3]) sp_in  = alu_res;
         if (mir.c_mask[4]) lv_in  = alu_res;
         if (mir.c_mask[5]) cpp_in = alu_res;
         if (mir.c_mask[6]) tos_in = alu_res;
         if (mir.c_mask[7]) opc_in = alu_res;
         if (mir.c_mask[8]) h_in   = alu_res;
      end

      if (do_mem) begin
         if (mir.mem_op[0]) mbr_in = fetch_rd[pc_ff[1:0]];
         if (mir.mem_op[1]) mdr_in = rd_word;
         mpc_in = mir.seq_addr;
         if ((mir.jam[0] && z_ff) || (mir.jam[1] && n_ff)) begin
            mpc_in[8] = 1'b1;
         end
         if (mir.jam[2]) begin
            mpc_in = {1'b0, mbr_in};
         end
      end
   end

   assign clr_row_in = do_clear ? clr_row_ff + ROW_W'(1) : clr_row_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         mpc_ff       <= '0;
         pc_ff        <= '0;
         mar_ff       <= '0;
         mdr_ff       <= '0;
         mbr_ff       <= '0;
         sp_ff        <= '0;
         lv_ff        <= '0;
         cpp_ff       <= '0;
         tos_ff       <= '0;
         opc_ff       <= '0;
         h_ff         <= '0;
         blatch_ff    <= '0;
         alu_ff       <= '0;
         n_ff         <= 1'b0;
         z_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
         mpc_ff       <= mpc_in;
         pc_ff        <= pc_in;
         mar_ff       <= mar_in;
         mdr_ff       <= mdr_in;
         mbr_ff       <= mbr_in;
         sp_ff        <= sp_in;
         lv_ff        <= lv_in;
         cpp_ff       <= cpp_in;
         tos_ff       <= tos_in;
         opc_ff       <= opc_in;
         h_ff         <= h_in;
         blatch_ff    <= blatch_in;
         alu_ff       <= alu_in;
         n_ff         <= n_in;
         z_ff         <= z_in;
      end
   end

   // payload: load word latch and result word
   always_ff @(posedge clock) begin
      if (accept) begin
         ld_func_ff <= req_func;
         ld_addr_ff <= req_addr;
         ld_data_ff <= req_data[7:0];
      end
      if (emit) begin
         rsp_mpc   <= mpc_in;
         rsp_pc    <= pc_in;
         rsp_mbr   <= mbr_in;
         rsp_mar   <= mar_in;
         rsp_mdr   <= mdr_in;
         rsp_sp    <= sp_in;
         rsp_lv    <= lv_in;
         rsp_cpp   <= cpp_in;
         rsp_tos   <= tos_in;
         rsp_opc   <= opc_in;
         rsp_hold  <= h_in;
         rsp_flags <= {n_in, z_in};
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- control store ----------------
   // Read address is the forwarded micro PC, so a step accepted in the memory
   // cycle fetches the microword the current step just selected.
   // Loads write straight from the request at accept; a step accepted in the
   // following cycle reads the new word.
   assign cs_wr_en = accept && (req_func == FUNC_CS_LOAD) && (req_addr[12:9] == 4'd0);

   mscd_ram #(
      .WIDTH (36),
      .DEPTH (512)
   ) u_cstore (
      .clock   (clock),
      .wr_en   (cs_wr_en),
      .wr_addr (req_addr[8:0]),
      .wr_data (req_data),
      .rd_en   (accept && (req_func == FUNC_STEP)),
      .rd_addr (mpc_in),
      .rd_data (cs_rd_data)
   );

   // ---------------- main memory lanes ----------------
   // Lane i holds bytes whose address is i mod 4; word accesses hit one row in
   // all lanes. Reads issue in the execute cycle, writes land in the memory cycle.
   for (genvar g = 0; g < 4; g++) begin : g_lane
      logic             wr_en;
      logic [ROW_W-1:0] wr_row;
      logic [7:0]       wr_byte;

      always_comb begin
         wr_en   = 1'b0;
         wr_row  = clr_row_ff;
         wr_byte = 8'h00;
         priority if (do_clear) begin
            wr_en = 1'b1;
         end else if (do_mem && mir.mem_op[2]) begin
            wr_en   = 1'b1;
            wr_row  = mar_ff[ROW_W-1:0];
            wr_byte = mdr_in[8*g +: 8];
         end else if (do_load && (ld_func_ff == FUNC_MEM_LOAD)
                      && (ld_addr_ext[1:0] == 2'(g))) begin
            wr_en   = 1'b1;
            wr_row  = ld_addr_ext[MEM_AW-1:2];
            wr_byte = ld_data_ff;
         end
      end

      mscd_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_word_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_row),
         .wr_data (wr_byte),
         .rd_en   (do_exec),
         .rd_addr (mar_in[ROW_W-1:0]),
         .rd_data (word_rd[g])
      );

      mscd_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_fetch_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_row),
         .wr_data (wr_byte),
         .rd_en   (do_exec),
         .rd_addr (pc_in[MEM_AW-1:2]),
         .rd_data (fetch_rd[g])
      );
   end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the microcoded stack CPU datapath: directed table, then random.
`timescale 1ns / 1ps

module tb_top
   import mscd_pkg::*;
;

   localparam int          MEM_BYTES   = 8192;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          RAND_WORDS  = 750;
   localparam logic [1:0]  FUNC_BAD    = 2'd3;   // undefined func, no state change
   // jump bits
   localparam int          JAM_Z  = 0;
   localparam int          JAM_N  = 1;
   localparam int          JAM_PC = 2;
   // memory bits
   localparam int          MEM_FETCH = 0;
   localparam int          MEM_READ  = 1;
   localparam int          MEM_WRITE = 2;
   // C-bus mask bits
   localparam int          C_MAR = 0, C_MDR = 1, C_PC = 2, C_SP = 3, C_LV = 4;
   localparam int          C_CPP = 5, C_TOS = 6, C_OPC = 7, C_H = 8;

   typedef struct packed {
      logic [8:0]  mpc;
      logic [31:0] pc;
      logic [7:0]  mbr;
      logic [31:0] mar;
      logic [31:0] mdr;
      logic [31:0] sp;
      logic [31:0] lv;
      logic [31:0] cpp;
      logic [31:0] tos;
      logic [31:0] opc;
      logic [31:0] hold;
      logic [1:0]  flags;
   } cpu_view_type;

   typedef struct {
      logic [1:0]  func;
      logic [12:0] addr;
      logic [35:0] data;
      bit          typed;     // mpc/flags given by hand
      logic [8:0]  mpc;
      logic [1:0]  flags;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [12:0] req_addr;
   logic [35:0] req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [8:0]  rsp_mpc;
   logic [31:0] rsp_pc;
   logic [7:0]  rsp_mbr;
   logic [31:0] rsp_mar;
   logic [31:0] rsp_mdr;
   logic [31:0] rsp_sp;
   logic [31:0] rsp_lv;
   logic [31:0] rsp_cpp;
   logic [31:0] rsp_tos;
   logic [31:0] rsp_opc;
   logic [31:0] rsp_hold;
   logic [1:0]  rsp_flags;

   microcoded_stack_cpu_datapath_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_addr  (req_addr),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_mpc   (rsp_mpc),
      .rsp_pc    (rsp_pc),
      .rsp_mbr   (rsp_mbr),
      .rsp_mar   (rsp_mar),
      .rsp_mdr   (rsp_mdr),
      .rsp_sp    (rsp_sp),
      .rsp_lv    (rsp_lv),
      .rsp_cpp   (rsp_cpp),
      .rsp_tos   (rsp_tos),
      .rsp_opc   (rsp_opc),
      .rsp_hold  (rsp_hold),
      .rsp_flags (rsp_flags)
   );

   // ---------------------------------------------------------------
   // Shadow machine state, advanced in input order
   // ---------------------------------------------------------------
   logic [35:0]  cstore [512];
   bit           cs_written [512];
   logic [7:0]   mem_img [MEM_BYTES];
   logic [8:0]   s_mpc;
   logic [31:0]  s_mar, s_mdr, s_pc, s_sp, s_lv, s_cpp, s_tos, s_opc, s_hold;
   logic [7:0]   s_mbr;
   logic [31:0]  s_bus, s_alu;
   logic         s_n, s_z;

   cpu_view_type pending_views [$];
   int           mismatches = 0;
   int           words_sent;
   int           cycles = 0;
   bit           long_hold_req;

   localparam logic [7:0] ALU_LIST [19] = '{ALU_A, ALU_B, ALU_SLL8, ALU_SRL8, ALU_SLL7SR1,
      ALU_NOT_A, ALU_NOT_B, ALU_ADD, ALU_ADD_INC, ALU_INC_A, ALU_INC_B, ALU_SUB,
      ALU_DEC_B, ALU_NEG_A, ALU_AND, ALU_OR, ALU_ZERO, ALU_ONE, ALU_ONES};

   function automatic logic [35:0] uword(input logic [8:0] nxt, input logic [2:0] jam,
                                         input logic [7:0] alu, input logic [8:0] mask,
                                         input logic [2:0] mem, input logic [3:0] bsel);
      uword_type w;
      w.seq_addr  = nxt;
      w.jam       = jam;
      w.alu_code  = alu;
      w.c_mask    = mask;
      w.mem_op    = mem;
      w.b_sel     = bsel;
      return w;
   endfunction

   // Apply one input word to the shadow state and queue the result it yields.
   task automatic advance_cpu(input logic [1:0] f, input logic [12:0] a, input logic [35:0] d);
      uword_type    w;
      logic [31:0]  base;
      logic [31:0]  rd;
      logic [8:0]   nxt;
      cpu_view_type v;
      case (f)
         FUNC_STEP: begin
            w = cstore[s_mpc];
            case (w.b_sel)
               BSEL_MDR:  s_bus = s_mdr;
               BSEL_PC:   s_bus = s_pc;
               BSEL_MBRU: s_bus = {24'd0, s_mbr};
               BSEL_MBRS: s_bus = {{24{s_mbr[7]}}, s_mbr};
               BSEL_SP:   s_bus = s_sp;
               BSEL_LV:   s_bus = s_lv;
               BSEL_CPP:  s_bus = s_cpp;
               BSEL_TOS:  s_bus = s_tos;
               BSEL_OPC:  s_bus = s_opc;
               default: ;
            endcase
            case (w.alu_code)
               ALU_A:       s_alu = s_hold;
               ALU_B:       s_alu = s_bus;
               ALU_SLL8:    s_alu = s_bus << 8;
               ALU_SRL8:    s_alu = s_bus >> 8;
               ALU_SLL7SR1: s_alu = (s_bus << 7) >> 1;
               ALU_NOT_A:   s_alu = ~s_hold;
               ALU_NOT_B:   s_alu = ~s_bus;
               ALU_ADD:     s_alu = s_hold + s_bus;
               ALU_ADD_INC: s_alu = s_hold + s_bus + 32'd1;
               ALU_INC_A:   s_alu = s_hold + 32'd1;
               ALU_INC_B:   s_alu = s_bus + 32'd1;
               ALU_SUB:     s_alu = s_bus - s_hold;
               ALU_DEC_B:   s_alu = s_bus - 32'd1;
               ALU_NEG_A:   s_alu = 32'd0 - s_hold;
               ALU_AND:     s_alu = s_hold & s_bus;
               ALU_OR:      s_alu = s_hold | s_bus;
               ALU_ZERO:    s_alu = 32'd0;
               ALU_ONE:     s_alu = 32'd1;
               ALU_ONES:    s_alu = 32'hFFFF_FFFF;
               default: ;   // unknown code keeps the last ALU output
            endcase
            s_n = s_alu[31];
            s_z = (s_alu == 32'd0);
            if (w.c_mask[C_MAR]) s_mar  = s_alu;
            if (w.c_mask[C_MDR]) s_mdr  = s_alu;
            if (w.c_mask[C_PC])  s_pc   = s_alu;
            if (w.c_mask[C_SP])  s_sp   = s_alu;
            if (w.c_mask[C_LV])  s_lv   = s_alu;
            if (w.c_mask[C_CPP]) s_cpp  = s_alu;
            if (w.c_mask[C_TOS]) s_tos  = s_alu;
            if (w.c_mask[C_OPC]) s_opc  = s_alu;
            if (w.c_mask[C_H])   s_hold = s_alu;
            base = s_mar << 2;
            if (w.mem_op[MEM_FETCH]) s_mbr = mem_img[s_pc % MEM_BYTES];
            if (w.mem_op[MEM_READ]) begin
               for (int i = 0; i < 4; i++) rd[8*i +: 8] = mem_img[(base + i) % MEM_BYTES];
               s_mdr = rd;
            end
            if (w.mem_op[MEM_WRITE])
               for (int i = 0; i < 4; i++) mem_img[(base + i) % MEM_BYTES] = s_mdr[8*i +: 8];
            nxt = w.seq_addr;
            if ((w.jam[JAM_Z] && s_z) || (w.jam[JAM_N] && s_n)) nxt[8] = 1'b1;
            if (w.jam[JAM_PC]) nxt = {1'b0, s_mbr};
            s_mpc = nxt;
         end
         FUNC_CS_LOAD: begin
            if (a < 13'd512) begin
               cstore[a[8:0]]     = d;
               cs_written[a[8:0]] = 1'b1;
            end
         end
         FUNC_MEM_LOAD: mem_img[a % MEM_BYTES] = d[7:0];
         default: ;
      endcase
      v = '{s_mpc, s_pc, s_mbr, s_mar, s_mdr, s_sp, s_lv, s_cpp, s_tos, s_opc, s_hold,
            {s_n, s_z}};
      pending_views.push_back(v);
   endtask

   // Gap before the next word: mostly none or short, a few long.
   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one word; returns at the edge that accepts it.
   task automatic send_word(input logic [1:0] f, input logic [12:0] a, input logic [35:0] d,
                            input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_addr  <= a;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   function automatic logic [35:0] random_uword();
      logic [7:0] alu;
      logic [2:0] jam;
      if ($urandom_range(0, 9) == 0) alu = 8'($urandom);
      else alu = ALU_LIST[$urandom_range(0, 18)];
      jam = 3'($urandom_range(0, 3));
      if ($urandom_range(0, 6) == 0) jam[JAM_PC] = 1'b1;
      return uword(9'($urandom), jam, alu, 9'($urandom), 3'($urandom),
                   4'($urandom_range(0, 15)));
   endfunction

   // ---------------------------------------------------------------
   // Clock, reset, cycle limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("microcoded_stack_cpu_datapath_core: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls, one long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      int r;
      bit long_done;
      long_done = 1'b0;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 9);
         if (long_hold_req && !long_done) begin
            long_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (r < 6) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else if (r < 9) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(15, 50)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cpu_view_type got;
      cpu_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_mpc, rsp_pc, rsp_mbr, rsp_mar, rsp_mdr, rsp_sp, rsp_lv, rsp_cpp,
                 rsp_tos, rsp_opc, rsp_hold, rsp_flags};
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
         end else begin
            want = pending_views.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch at cycle %0d", cycles);
                  $display("  expected mpc %h pc %h mbr %h mar %h mdr %h sp %h lv %h",
                           want.mpc, want.pc, want.mbr, want.mar, want.mdr, want.sp, want.lv);
                  $display("           cpp %h tos %h opc %h h %h flags %b",
                           want.cpp, want.tos, want.opc, want.hold, want.flags);
                  $display("  actual   mpc %h pc %h mbr %h mar %h mdr %h sp %h lv %h",
                           got.mpc, got.pc, got.mbr, got.mar, got.mdr, got.sp, got.lv);
                  $display("           cpp %h tos %h opc %h h %h flags %b",
                           got.cpp, got.tos, got.opc, got.hold, got.flags);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   dir_row_type dir_rows [14];

   initial begin
      int          target;
      int          r;
      int          burst;
      logic [35:0] uw;
      logic [12:0] ad;
      bit          hold_asked;
      bit          drained;
      req_valid     = 1'b0;
      req_func      = FUNC_STEP;
      req_addr      = '0;
      req_data      = '0;
      words_sent    = 0;
      long_hold_req = 1'b0;
      hold_asked    = 1'b0;
      drained       = 1'b0;
      burst         = 0;
      s_mpc = '0; s_mar = '0; s_mdr = '0; s_pc = '0; s_sp = '0; s_lv = '0; s_cpp = '0;
      s_tos = '0; s_opc = '0; s_hold = '0; s_mbr = '0; s_bus = '0; s_alu = '0;
      s_n = 1'b0; s_z = 1'b0;
      for (int i = 0; i < 512; i++) cs_written[i] = 1'b0;
      for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = '0;

      // undefined func right after reset reports the cleared state
      dir_rows[0]  = '{FUNC_BAD, 13'h1FFF, 36'hF_FFFF_FFFF, 1'b1, 9'd0, 2'b00};
      dir_rows[1]  = '{FUNC_CS_LOAD, 13'd0, uword(9'd1, 3'b000, ALU_ONES, 9'h100, 3'b000,
                       BSEL_MDR), 1'b1, 9'd0, 2'b00};
      // load past the control store end is dropped
      dir_rows[2]  = '{FUNC_CS_LOAD, 13'd600, 36'hF_FFFF_FFFF, 1'b1, 9'd0, 2'b00};
      dir_rows[3]  = '{FUNC_MEM_LOAD, 13'h1FFF, 36'hF_FFFF_FFFF, 1'b1, 9'd0, 2'b00};
      dir_rows[4]  = '{FUNC_MEM_LOAD, 13'd0, 36'h0_0000_0080, 1'b1, 9'd0, 2'b00};
      // H = all ones, N set
      dir_rows[5]  = '{FUNC_STEP, 13'd0, 36'd0, 1'b1, 9'd1, 2'b10};
      // H+1 wraps to zero, JAMZ takes the high half; fetch gets 0x80
      dir_rows[6]  = '{FUNC_CS_LOAD, 13'd1, uword(9'd2, 3'b001, ALU_INC_A, 9'h101, 3'b001,
                       BSEL_MBRS), 1'b0, 9'd0, 2'b00};
      dir_rows[7]  = '{FUNC_STEP, 13'd0, 36'd0, 1'b1, 9'h102, 2'b01};
      // sign-extended MBR into MAR/MDR/PC, read and write together at a wrapped address
      dir_rows[8]  = '{FUNC_CS_LOAD, 13'h102, uword(9'd3, 3'b010, ALU_ADD, 9'h007, 3'b110,
                       BSEL_MBRS), 1'b0, 9'd0, 2'b00};
      dir_rows[9]  = '{FUNC_STEP, 13'd0, 36'd0, 1'b1, 9'h103, 2'b10};
      // unknown ALU code and unknown B select, JMPC from fetched byte
      dir_rows[10] = '{FUNC_CS_LOAD, 13'h103, uword(9'h1FF, 3'b100, 8'h77, 9'h0F0, 3'b001,
                       4'hF), 1'b0, 9'd0, 2'b00};
      dir_rows[11] = '{FUNC_STEP, 13'd0, 36'd0, 1'b0, 9'd0, 2'b00};
      dir_rows[12] = '{FUNC_STEP, 13'd0, 36'd0, 1'b0, 9'd0, 2'b00};
      dir_rows[13] = '{FUNC_BAD, 13'd0, 36'd0, 1'b0, 9'd0, 2'b00};

      @(posedge clock);
      foreach (dir_rows[i]) begin
         advance_cpu(dir_rows[i].func, dir_rows[i].addr, dir_rows[i].data);
         if (dir_rows[i].typed) begin
            pending_views[$].mpc   = dir_rows[i].mpc;
            pending_views[$].flags = dir_rows[i].flags;
         end
         send_word(dir_rows[i].func, dir_rows[i].addr, dir_rows[i].data, sender_gap());
      end

      // Random part: mostly microcycles over a control store that is kept
      // written at every address the micro PC lands on.
      target = words_sent + RAND_WORDS;
      while (words_sent < target) begin
         if (!hold_asked && words_sent >= target - 600) begin
            hold_asked    = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!drained && words_sent >= target - 300) begin
            // let the datapath drain completely
            drained = 1'b1;
            req_valid <= 1'b0;
            while (pending_views.size() != 0) @(posedge clock);
         end
         if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            uw = 36'({$urandom, $urandom});
            ad = 13'($urandom);
            advance_cpu(FUNC_MEM_LOAD, ad, uw);
            send_word(FUNC_MEM_LOAD, ad, uw, burst > 0 ? 0 : sender_gap());
         end else if (r < 11) begin
            uw = 36'({$urandom, $urandom});
            ad = 13'($urandom);
            advance_cpu(FUNC_BAD, ad, uw);
            send_word(FUNC_BAD, ad, uw, burst > 0 ? 0 : sender_gap());
         end else if (r < 14) begin
            uw = 36'({$urandom, $urandom});
            ad = 13'($urandom);
            advance_cpu(FUNC_CS_LOAD, ad, uw);
            send_word(FUNC_CS_LOAD, ad, uw, burst > 0 ? 0 : sender_gap());
         end else begin
            if (!cs_written[s_mpc] || $urandom_range(0, 9) < 4) begin
               uw = random_uword();
               advance_cpu(FUNC_CS_LOAD, {4'd0, s_mpc}, uw);
               send_word(FUNC_CS_LOAD, {4'd0, s_mpc}, uw, burst > 0 ? 0 : sender_gap());
            end
            uw = 36'({$urandom, $urandom});
            ad = 13'($urandom);
            advance_cpu(FUNC_STEP, ad, uw);
            send_word(FUNC_STEP, ad, uw, burst > 0 ? 0 : sender_gap());
         end
         if (burst > 0) burst--;
      end

      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("microcoded_stack_cpu_datapath_core: match");
      end else begin
         $display("microcoded_stack_cpu_datapath_core: mismatch");
      end
      $finish;
   end

endmodule
